@@ rtl/mrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants of the multigrid restriction/prolongation store.
// ----------------------------------------------------------------------------
package mrp_pkg;

   localparam int FUNC_W = 2;
   localparam int INDEX_W = 11;
   localparam int CMD_INDEX_W = INDEX_W - 1;
   localparam int FIELD_W = 32;
   localparam int EPOCH_W = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_ACCUM,
      KIND_READ,
      KIND_SKIP,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [CMD_INDEX_W-1:0]  index;
      logic signed [FIELD_W-1:0] fine_value;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/mrp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_queue
// Short first-in first-out queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module mrp_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire mrp_pkg::cmd_type push_cmd,
   output logic                 full,
   input  wire logic            pop,
   output mrp_pkg::cmd_type     head_cmd,
   output logic                 empty
);

   localparam int AW = (mrp_pkg::QUEUE_DEPTH > 1) ? $clog2(mrp_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(mrp_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(mrp_pkg::QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(mrp_pkg::QUEUE_DEPTH - 1);

   mrp_pkg::cmd_type entry_ff [mrp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/mrp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_front
// Accepts requests, decodes the function and checks the coarse index.
// ----------------------------------------------------------------------------
module mrp_front #(
   parameter int COARSE_DEPTH = 1024
) (
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [mrp_pkg::FUNC_W-1:0]          req_func,
   input  wire logic signed [mrp_pkg::INDEX_W-1:0]  req_coarse_index,
   input  wire logic signed [mrp_pkg::FIELD_W-1:0]  req_fine_value,
   input  wire logic                                queue_full,
   input  wire logic                                sweep_busy,
   output logic                                     push,
   output mrp_pkg::cmd_type                         push_cmd
);

   logic in_range;

   assign req_stall = queue_full || sweep_busy;
   assign push = req_valid && !req_stall;

   always_comb begin
      in_range = !req_coarse_index[mrp_pkg::INDEX_W-1] &&
         (32'(req_coarse_index[mrp_pkg::CMD_INDEX_W-1:0]) < 32'(COARSE_DEPTH));
      push_cmd.index = req_coarse_index[mrp_pkg::CMD_INDEX_W-1:0];
      push_cmd.fine_value = req_fine_value;
      unique case (req_func)
         mrp_pkg::FUNC_CLEAR: push_cmd.kind = mrp_pkg::KIND_CLEAR;
         mrp_pkg::FUNC_ACCUM: push_cmd.kind = in_range ? mrp_pkg::KIND_ACCUM : mrp_pkg::KIND_SKIP;
         mrp_pkg::FUNC_READ:  push_cmd.kind = in_range ? mrp_pkg::KIND_READ : mrp_pkg::KIND_SKIP;
         default:             push_cmd.kind = mrp_pkg::KIND_NONE;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/mrp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_back
// Coarse sum memory with epoch tags, read-modify-write pipeline with
// forwarding, saturation and the response register.
// ----------------------------------------------------------------------------
module mrp_back #(
   parameter int COARSE_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               queue_empty,
   input  wire mrp_pkg::cmd_type                   head_cmd,
   output logic                                    pop,
   output logic                                    sweep_busy,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mrp_pkg::FIELD_W-1:0]      rsp_entry_value,
   output logic                                    rsp_saturated,
   output logic                                    rsp_skipped
);

   localparam int ADDR_W = $clog2(COARSE_DEPTH);
   localparam int EW = mrp_pkg::EPOCH_W;
   localparam int MEM_W = EW + VALUE_WIDTH;
   localparam int SUM_W = ((VALUE_WIDTH > mrp_pkg::FIELD_W) ? VALUE_WIDTH : mrp_pkg::FIELD_W) + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(COARSE_DEPTH - 1);
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

   logic [MEM_W-1:0] mem [COARSE_DEPTH];

   logic sweep_ff, sweep_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [EW-1:0] epoch_ff, epoch_in;

   logic b1_valid_ff, b1_valid_in;
   mrp_pkg::cmd_type b1_cmd_ff;
   logic [MEM_W-1:0] b1_word_ff;
   logic b2_valid_ff, b2_valid_in;
   mrp_pkg::cmd_type b2_cmd_ff;
   logic [MEM_W-1:0] b2_word_ff;

   logic fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic signed [VALUE_WIDTH-1:0] fwd_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [mrp_pkg::FIELD_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_sat_ff, rsp_sat_in;
   logic rsp_skip_ff, rsp_skip_in;

   logic clear_block, b1_move, b2_done, acc_write;
   logic [ADDR_W-1:0] rd_addr, b2_addr, wr_addr;
   logic wr_en;
   logic [MEM_W-1:0] wr_word;
   logic signed [VALUE_WIDTH-1:0] cur, acc_val, res;
   logic signed [SUM_W-1:0] sum_ext, res_ext;
   logic acc_sat;

   assign rd_addr = ADDR_W'(head_cmd.index);
   assign b2_addr = ADDR_W'(b2_cmd_ff.index);

   assign b2_done = b2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b1_move = b1_valid_ff && (!b2_valid_ff || b2_done);
   assign clear_block = (b1_valid_ff && (b1_cmd_ff.kind == mrp_pkg::KIND_CLEAR)) ||
                        (b2_valid_ff && (b2_cmd_ff.kind == mrp_pkg::KIND_CLEAR));
   assign pop = !queue_empty && !sweep_ff && !clear_block && (!b1_valid_ff || b1_move);
   assign acc_write = b2_done && (b2_cmd_ff.kind == mrp_pkg::KIND_ACCUM);
   assign sweep_busy = sweep_ff;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == b2_addr)) begin
         cur = fwd_data_ff;
      end else if (b2_word_ff[MEM_W-1 -: EW] == epoch_ff) begin
         cur = b2_word_ff[VALUE_WIDTH-1:0];
      end else begin
         cur = '0;
      end
      sum_ext = SUM_W'(cur) + SUM_W'($signed(b2_cmd_ff.fine_value));
      acc_sat = 1'b0;
      if (sum_ext > SUM_MAX) begin
         acc_val = VALUE_WIDTH'(SUM_MAX);
         acc_sat = 1'b1;
      end else if (sum_ext < SUM_MIN) begin
         acc_val = VALUE_WIDTH'(SUM_MIN);
         acc_sat = 1'b1;
      end else begin
         acc_val = VALUE_WIDTH'(sum_ext);
      end

      res = '0;
      rsp_sat_in = 1'b0;
      rsp_skip_in = 1'b0;
      unique case (b2_cmd_ff.kind)
         mrp_pkg::KIND_ACCUM: begin
            res = acc_val;
            rsp_sat_in = acc_sat;
         end
         mrp_pkg::KIND_READ: res = cur;
         mrp_pkg::KIND_SKIP: rsp_skip_in = 1'b1;
         default: res = '0;
      endcase
      res_ext = SUM_W'(res);
      rsp_value_in = res_ext[mrp_pkg::FIELD_W-1:0];
      rsp_valid_in = b2_done || (rsp_valid_ff && rsp_stall);

      wr_en = sweep_ff || acc_write;
      wr_addr = sweep_ff ? sweep_addr_ff : b2_addr;
      wr_word = sweep_ff ? {mrp_pkg::EPOCH_STALE, {VALUE_WIDTH{1'b0}}} : {epoch_ff, acc_val};

      b1_valid_in = pop || (b1_valid_ff && !b1_move);
      b2_valid_in = b1_move || (b2_valid_ff && !b2_done);

      fwd_valid_in = fwd_valid_ff;
      if (acc_write) begin
         fwd_valid_in = 1'b1;
      end

      sweep_in = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      epoch_in = epoch_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == LAST_ADDR) begin
            sweep_in = 1'b0;
         end
      end else if (b2_done && (b2_cmd_ff.kind == mrp_pkg::KIND_CLEAR)) begin
         fwd_valid_in = 1'b0;
         if (epoch_ff == mrp_pkg::EPOCH_LAST) begin
            sweep_in = 1'b1;
            sweep_addr_in = '0;
            epoch_in = mrp_pkg::EPOCH_FIRST;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 1'b1;
         sweep_addr_ff <= '0;
         epoch_ff <= mrp_pkg::EPOCH_FIRST;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         epoch_ff <= epoch_in;
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      if (pop) begin
         b1_cmd_ff <= head_cmd;
         b1_word_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_word : mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (b1_move) begin
         b2_cmd_ff <= b1_cmd_ff;
         b2_word_ff <= b1_word_ff;
      end
      if (acc_write) begin
         fwd_addr_ff <= b2_addr;
         fwd_data_ff <= acc_val;
      end
      if (b2_done) begin
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff <= rsp_sat_in;
         rsp_skip_ff <= rsp_skip_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_skipped = rsp_skip_ff;

endmodule
`default_nettype wire

@@ rtl/multigrid_restrict_prolong_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multigrid_restrict_prolong_top
// Coarse-level sum store: clear, accumulate with saturation, and read.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (req_valid/req_stall) with a function,
// a coarse index and a fine value. Each request produces exactly one response
// on the rsp_ channel (rsp_valid/rsp_stall) in request order.
// A request is classified in the front, waits in a two-entry queue and then
// passes a memory read stage and an update stage before the response register.
// Reads and accumulates sustain one request per cycle when nothing stalls;
// back-to-back accumulates to the same entry use forwarding from the last
// write. A clear bumps an epoch tag and holds issue while it is in the read or
// update stage. Every 255th clear the tag wraps and a sweep rewrites all
// COARSE_DEPTH memory entries, one per cycle, while req_stall is high. After
// reset the same sweep runs before the first request is accepted. A stalled
// response holds in the output register while the queue keeps accepting until
// it is full, then req_stall rises.
// ----------------------------------------------------------------------------
module multigrid_restrict_prolong_top #(
   parameter int COARSE_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [mrp_pkg::FUNC_W-1:0]          req_func,
   input  wire logic signed [mrp_pkg::INDEX_W-1:0]  req_coarse_index,
   input  wire logic signed [mrp_pkg::FIELD_W-1:0]  req_fine_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [mrp_pkg::FIELD_W-1:0]       rsp_entry_value,
   output logic                                     rsp_saturated,
   output logic                                     rsp_skipped
);

   logic queue_full, queue_empty, push, pop, sweep_busy;
   mrp_pkg::cmd_type push_cmd, head_cmd;

   mrp_front #(
      .COARSE_DEPTH(COARSE_DEPTH)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_coarse_index(req_coarse_index),
      .req_fine_value(req_fine_value),
      .queue_full(queue_full),
      .sweep_busy(sweep_busy),
      .push(push),
      .push_cmd(push_cmd)
   );

   mrp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .full(queue_full),
      .pop(pop),
      .head_cmd(head_cmd),
      .empty(queue_empty)
   );

   mrp_back #(
      .COARSE_DEPTH(COARSE_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .head_cmd(head_cmd),
      .pop(pop),
      .sweep_busy(sweep_busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_entry_value(rsp_entry_value),
      .rsp_saturated(rsp_saturated),
      .rsp_skipped(rsp_skipped)
   );

endmodule
`default_nettype wire

@@ rtl/mrp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks of the coarse sum store, bound to the top level.
// ----------------------------------------------------------------------------
module mrp_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [mrp_pkg::FIELD_W-1:0]  rsp_entry_value,
   input wire logic                                rsp_saturated,
   input wire logic                                rsp_skipped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Response dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_entry_value) && $stable(rsp_saturated)
         && $stable(rsp_skipped))
      else $error("Response payload changed while stalled.");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |-> (rsp_entry_value == '0) && !rsp_saturated)
      else $error("Skipped response carries a value or saturation.");

   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("Request accepted during the clearing pass after reset.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind multigrid_restrict_prolong_top mrp_checker u_mrp_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_entry_value(rsp_entry_value),
   .rsp_saturated(rsp_saturated),
   .rsp_skipped(rsp_skipped)
);
`default_nettype wire

@@ bench/multigrid_restrict_prolong_top_test.sv @@
// ----------------------------------------------------------------------------
// multigrid_restrict_prolong_top_test
// Self-checking bench for the coarse-level sum store.
// A clocked driver presents requests from a backlog that the stimulus block
// fills phase by phase. A behavioral copy of the store predicts each response
// at acceptance, and a clocked monitor compares every response field with the
// oldest prediction. Directed requests cover the value and index extremes,
// saturation in both directions, skipped entries and clears. Random traffic
// concentrates on a few hot entries so that sums saturate, and a long run of
// clears drives the epoch tag through its wrap. Sender gaps and receiver
// stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module multigrid_restrict_prolong_top_test;

   localparam int COARSE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam logic [mrp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic signed [mrp_pkg::FIELD_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [mrp_pkg::FIELD_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam longint SUM_HI = longint'(VALUE_MAX);
   localparam longint SUM_LO = longint'(VALUE_MIN);
   localparam int WRAP_CLEARS = 258;
   localparam int ALIAS_SLOT = 500;

   typedef struct {
      logic [mrp_pkg::FUNC_W-1:0]          func;
      logic signed [mrp_pkg::INDEX_W-1:0]  coarse_index;
      logic signed [mrp_pkg::FIELD_W-1:0]  fine_value;
   } coarse_request_type;

   typedef struct {
      logic signed [mrp_pkg::FIELD_W-1:0]  entry_value;
      logic                                saturated;
      logic                                skipped;
   } coarse_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [mrp_pkg::FUNC_W-1:0] req_func = '0;
   logic signed [mrp_pkg::INDEX_W-1:0] req_coarse_index = '0;
   logic signed [mrp_pkg::FIELD_W-1:0] req_fine_value = '0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic signed [mrp_pkg::FIELD_W-1:0] rsp_entry_value;
   logic rsp_saturated;
   logic rsp_skipped;

   coarse_request_type request_backlog[$];
   coarse_request_type presented;
   coarse_reply_type pending_replies[$];
   int mismatch_count = 0;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;

   logic signed [mrp_pkg::FIELD_W-1:0] coarse_sum_model [COARSE_DEPTH];
   logic [COARSE_DEPTH-1:0] entry_live = '0;
   logic [COARSE_DEPTH-1:0] slot_ever_written = '0;
   int written_slots[$];

   multigrid_restrict_prolong_top #(
      .COARSE_DEPTH(COARSE_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_coarse_index(req_coarse_index),
      .req_fine_value(req_fine_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_entry_value(rsp_entry_value),
      .rsp_saturated(rsp_saturated),
      .rsp_skipped(rsp_skipped)
   );

   always #6 clock = ~clock;

   function automatic coarse_reply_type apply_store_request(coarse_request_type r);
      coarse_reply_type reply;
      longint cur;
      longint sum;
      int slot;
      reply = '{entry_value: '0, saturated: 1'b0, skipped: 1'b0};
      slot = int'(r.coarse_index);
      if (r.func == mrp_pkg::FUNC_CLEAR) begin
         entry_live = '0;
      end else if (r.func == mrp_pkg::FUNC_ACCUM || r.func == mrp_pkg::FUNC_READ) begin
         if (slot < 0 || slot >= COARSE_DEPTH) begin
            reply.skipped = 1'b1;
         end else begin
            cur = entry_live[slot] ? longint'(coarse_sum_model[slot]) : 0;
            if (r.func == mrp_pkg::FUNC_ACCUM) begin
               sum = cur + longint'(r.fine_value);
               if (sum > SUM_HI) begin
                  sum = SUM_HI;
                  reply.saturated = 1'b1;
               end else if (sum < SUM_LO) begin
                  sum = SUM_LO;
                  reply.saturated = 1'b1;
               end
               coarse_sum_model[slot] = mrp_pkg::FIELD_W'(sum);
               entry_live[slot] = 1'b1;
               cur = sum;
            end
            reply.entry_value = mrp_pkg::FIELD_W'(cur);
         end
      end
      return reply;
   endfunction

   task automatic queue_request(logic [mrp_pkg::FUNC_W-1:0] f,
                                logic signed [mrp_pkg::INDEX_W-1:0] idx,
                                logic signed [mrp_pkg::FIELD_W-1:0] v);
      request_backlog.push_back('{func: f, coarse_index: idx, fine_value: v});
      if (f == mrp_pkg::FUNC_ACCUM && idx >= 0 && !slot_ever_written[idx]) begin
         slot_ever_written[idx] = 1'b1;
         written_slots.push_back(int'(idx));
      end
   endtask

   function automatic logic signed [mrp_pkg::INDEX_W-1:0] pick_hot();
      int h;
      h = $urandom_range(0, 7);
      return mrp_pkg::INDEX_W'(h < 6 ? h : COARSE_DEPTH - 8 + h);
   endfunction

   function automatic logic signed [mrp_pkg::INDEX_W-1:0] pick_target();
      if ($urandom_range(0, 99) < 60) return pick_hot();
      return mrp_pkg::INDEX_W'($urandom_range(0, COARSE_DEPTH - 1));
   endfunction

   function automatic logic signed [mrp_pkg::FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return ($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1;
         4, 5, 6: return $urandom;
         default: return mrp_pkg::FIELD_W'(int'($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   task automatic queue_random_request();
      int roll;
      logic signed [mrp_pkg::INDEX_W-1:0] slot;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         queue_request(mrp_pkg::FUNC_CLEAR, mrp_pkg::INDEX_W'($urandom), $urandom);
      end else if (roll < 12) begin
         slot = ($urandom_range(0, 1) != 0) ? '1 : {1'b1, 10'($urandom)};
         queue_request(($urandom_range(0, 1) != 0) ? mrp_pkg::FUNC_ACCUM : mrp_pkg::FUNC_READ,
                       slot, $urandom);
      end else if (roll < 56 || written_slots.size() == 0) begin
         queue_request(mrp_pkg::FUNC_ACCUM, pick_target(), pick_value());
      end else begin
         slot = pick_target();
         if (!slot_ever_written[slot]) begin
            slot = mrp_pkg::INDEX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
         end
         queue_request(mrp_pkg::FUNC_READ, slot, $urandom);
      end
   endtask

   task automatic drain_backlog();
      while (request_backlog.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      coarse_request_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_replies.push_back(apply_store_request(presented));
         end
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               upcoming = request_backlog.pop_front();
               presented = upcoming;
               req_valid <= 1'b1;
               req_func <= upcoming.func;
               req_coarse_index <= upcoming.coarse_index;
               req_fine_value <= upcoming.fine_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      coarse_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $display("%0t unexpected response: entry_value %0d saturated %0b skipped %0b",
                        $time, rsp_entry_value, rsp_saturated, rsp_skipped);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_entry_value !== want.entry_value) begin
                  $display("%0t entry_value mismatch: expected %0d, actual %0d",
                           $time, want.entry_value, rsp_entry_value);
                  mismatch_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t saturated mismatch: expected %0b, actual %0b",
                           $time, want.saturated, rsp_saturated);
                  mismatch_count++;
               end
               if (rsp_skipped !== want.skipped) begin
                  $display("%0t skipped mismatch: expected %0b, actual %0b",
                           $time, want.skipped, rsp_skipped);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin
      logic signed [mrp_pkg::INDEX_W-1:0] slot;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct = 0;
      recv_stall_pct = 0;
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, 32'sd5);
      queue_request(mrp_pkg::FUNC_READ, 11'sd0, VALUE_MAX);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, VALUE_MAX);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, VALUE_MIN);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, VALUE_MIN);
      queue_request(mrp_pkg::FUNC_READ, 11'sd0, '0);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd1023, -32'sd1);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd1023, '0);
      queue_request(mrp_pkg::FUNC_READ, 11'sd1023, -32'sd1);
      queue_request(mrp_pkg::FUNC_ACCUM, '1, 32'sd7);
      queue_request(mrp_pkg::FUNC_READ, '1, 32'sd7);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'h400, VALUE_MAX);
      queue_request(mrp_pkg::FUNC_READ, 11'h400, VALUE_MIN);
      queue_request(FUNC_UNUSED, 11'sd5, 32'sd9);
      queue_request(mrp_pkg::FUNC_CLEAR, 11'sd3, 32'sd123);
      queue_request(mrp_pkg::FUNC_READ, 11'sd0, '0);
      queue_request(mrp_pkg::FUNC_READ, 11'sd1023, '0);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, VALUE_MIN);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, -32'sd1);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd1, VALUE_MAX);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd1, 32'sd1);
      queue_request(mrp_pkg::FUNC_READ, 11'sd1, '0);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd1, VALUE_MIN);
      queue_request(mrp_pkg::FUNC_CLEAR, '1, '1);
      queue_request(mrp_pkg::FUNC_ACCUM, 11'sd0, 32'sd1);
      drain_backlog();

      for (int p = 0; p < 4; p++) begin
         send_gap_pct = (p == 0) ? 60 : (p == 2) ? 6 : 0;
         recv_stall_pct = (p == 1) ? 60 : (p == 2) ? 6 : 0;
         repeat (30) queue_random_request();
         drain_backlog();
      end

      // Enough clears to wrap the epoch tag; the alias entry is written once
      // and must keep reading as zero across the wrap.
      queue_request(mrp_pkg::FUNC_ACCUM, mrp_pkg::INDEX_W'(ALIAS_SLOT), 32'sd77);
      for (int half = 0; half < 2; half++) begin
         send_gap_pct = (half == 0) ? 60 : 6;
         recv_stall_pct = (half == 0) ? 6 : 60;
         for (int n = 0; n < WRAP_CLEARS / 2; n++) begin
            queue_request(mrp_pkg::FUNC_CLEAR, mrp_pkg::INDEX_W'($urandom), $urandom);
            slot = pick_hot();
            queue_request(mrp_pkg::FUNC_ACCUM, slot, pick_value());
            if (n % 10 == 0) queue_request(mrp_pkg::FUNC_READ, slot, $urandom);
            if (n % 25 == 24) begin
               queue_request(mrp_pkg::FUNC_READ, mrp_pkg::INDEX_W'(ALIAS_SLOT), $urandom);
            end
         end
         drain_backlog();
      end

      while (request_backlog.size() != 0 || req_valid || pending_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("status: fail");
      $finish;
   end

endmodule
